[hdl/bbg_pkg.sv]
// ----------------------------------------------------------------------------
// bbg_pkg
// Types and constants shared by the battery bar gauge modules.
// ----------------------------------------------------------------------------
package bbg_pkg;

    localparam int CellWidth  = 16;
    localparam int MvWidth    = 13;
    localparam int HystWidth  = 8;
    localparam int SumWidth   = MvWidth + 2;
    localparam int BarWidth   = 3;
    localparam int NumLevels  = 4;
    localparam int CfgIdxWidth = 3;

    // Mean of three cells: multiply by ceil(2^17 / 3) and shift right by 17.
    // Exact for every sum below 2^17.
    localparam int RecipShift = 17;
    localparam logic [15:0] RECIP_THIRD = 16'd43691;
    localparam int ProdWidth = SumWidth + 16;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_THR_ONE   = 3'd0,
        REG_THR_TWO   = 3'd1,
        REG_THR_THREE = 3'd2,
        REG_THR_FOUR  = 3'd3,
        REG_HYST      = 3'd4,
        REG_VALID_LOW = 3'd5,
        REG_VALID_HI  = 3'd6
    } cfg_index_t;

    localparam logic [MvWidth-1:0]   RST_THR_ONE   = 13'd3300;
    localparam logic [MvWidth-1:0]   RST_THR_TWO   = 13'd3600;
    localparam logic [MvWidth-1:0]   RST_THR_THREE = 13'd3800;
    localparam logic [MvWidth-1:0]   RST_THR_FOUR  = 13'd4000;
    localparam logic [HystWidth-1:0] RST_HYST      = 8'd25;
    localparam logic [MvWidth-1:0]   RST_VALID_LOW = 13'd2500;
    localparam logic [MvWidth-1:0]   RST_VALID_HI  = 13'd4500;

    localparam logic [BarWidth-1:0] BAR_MAX = 3'd4;

    typedef struct packed {
        logic [NumLevels-1:0][MvWidth-1:0] thr;   // thr[k] is the level k+1 threshold
        logic [HystWidth-1:0]              hyst;
        logic [MvWidth-1:0]                valid_low;
        logic [MvWidth-1:0]                valid_high;
    } cfg_t;

    // Word passed from the front stage to the level stage.
    typedef struct packed {
        logic               ok;
        logic [MvWidth-1:0] mean;
    } meas_t;

endpackage

[hdl/bbg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bbg_cfg_regs
// Configuration register file: thresholds, hysteresis and cell window.
// ----------------------------------------------------------------------------
module bbg_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bbg_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [bbg_pkg::MvWidth-1:0]     cfg_data,
    output bbg_pkg::cfg_t                   cfg
);
    import bbg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg.thr[0]     <= RST_THR_ONE;
            cfg_reg.thr[1]     <= RST_THR_TWO;
            cfg_reg.thr[2]     <= RST_THR_THREE;
            cfg_reg.thr[3]     <= RST_THR_FOUR;
            cfg_reg.hyst       <= RST_HYST;
            cfg_reg.valid_low  <= RST_VALID_LOW;
            cfg_reg.valid_high <= RST_VALID_HI;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_THR_ONE:   cfg_reg.thr[0]     <= cfg_data;
                REG_THR_TWO:   cfg_reg.thr[1]     <= cfg_data;
                REG_THR_THREE: cfg_reg.thr[2]     <= cfg_data;
                REG_THR_FOUR:  cfg_reg.thr[3]     <= cfg_data;
                REG_HYST:      cfg_reg.hyst       <= cfg_data[HystWidth-1:0];
                REG_VALID_LOW: cfg_reg.valid_low  <= cfg_data;
                REG_VALID_HI:  cfg_reg.valid_high <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/bbg_front.sv]
// ----------------------------------------------------------------------------
// bbg_front
// Input register, then cell window check and mean of the three cells.
// ----------------------------------------------------------------------------
module bbg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bbg_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bbg_pkg::CellWidth-1:0] cell_a_mv,
    input  logic [bbg_pkg::CellWidth-1:0] cell_b_mv,
    input  logic [bbg_pkg::CellWidth-1:0] cell_c_mv,
    input  logic                          monitor_present,
    output logic                          meas_valid,
    input  logic                          meas_take,
    output bbg_pkg::meas_t                meas
);
    import bbg_pkg::*;

    logic                 in_full_reg;
    logic [CellWidth-1:0] a_reg, b_reg, c_reg;
    logic                 present_reg;
    logic                 meas_full_reg;
    meas_t                meas_reg;
    meas_t                meas_next;

    logic                 meas_en;
    logic                 in_en;
    logic                 a_ok, b_ok, c_ok;
    logic [SumWidth-1:0]  sum;
    logic [ProdWidth-1:0] prod;

    // A stage loads when it is empty or its word moves on in the same cycle.
    assign meas_en  = !meas_full_reg || meas_take;
    assign in_en    = !in_full_reg || meas_en;
    assign in_stall = !in_en;

    function automatic logic cell_in_window(input logic [CellWidth-1:0] cell_mv,
                                            input logic [MvWidth-1:0]   lo,
                                            input logic [MvWidth-1:0]   hi);
        logic [CellWidth-2:0] mag;
        mag = cell_mv[CellWidth-2:0];
        return !cell_mv[CellWidth-1]
            && (mag >= (CellWidth-1)'(lo))
            && (mag <= (CellWidth-1)'(hi));
    endfunction

    always_comb begin
        a_ok = cell_in_window(a_reg, cfg.valid_low, cfg.valid_high);
        b_ok = cell_in_window(b_reg, cfg.valid_low, cfg.valid_high);
        c_ok = cell_in_window(c_reg, cfg.valid_low, cfg.valid_high);
        // Cells of a valid reading are below 8192, so the low bits carry them fully.
        sum  = SumWidth'(a_reg[MvWidth-1:0]) + SumWidth'(b_reg[MvWidth-1:0])
             + SumWidth'(c_reg[MvWidth-1:0]);
        prod = ProdWidth'(sum) * ProdWidth'(RECIP_THIRD);
        meas_next.ok   = present_reg && a_ok && b_ok && c_ok;
        meas_next.mean = prod[RecipShift +: MvWidth];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            meas_full_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
            begin
                in_full_reg <= in_valid;
            end
            if (meas_en)
            begin
                meas_full_reg <= in_full_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_en && in_valid)
        begin
            a_reg       <= cell_a_mv;
            b_reg       <= cell_b_mv;
            c_reg       <= cell_c_mv;
            present_reg <= monitor_present;
        end
        if (meas_en && in_full_reg)
        begin
            meas_reg <= meas_next;
        end
    end

    assign meas_valid = meas_full_reg;
    assign meas = meas_reg;

endmodule

[hdl/bbg_level.sv]
// ----------------------------------------------------------------------------
// bbg_level
// Bar level state with placement and hysteresis stepping, and result register.
// ----------------------------------------------------------------------------
module bbg_level (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbg_pkg::cfg_t                cfg,
    input  logic                         meas_valid,
    output logic                         meas_take,
    input  bbg_pkg::meas_t               meas,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bbg_pkg::BarWidth-1:0] bar_count,
    output logic                         reading_valid
);
    import bbg_pkg::*;

    logic                level_known_reg;
    logic [BarWidth-1:0] bar_level_reg;
    logic [BarWidth-1:0] bar_level_next;
    logic                out_valid_reg;
    logic [BarWidth-1:0] bar_count_reg;
    logic                reading_valid_reg;

    logic                out_en;
    logic                load;
    logic [NumLevels-1:0] reach;
    logic [NumLevels-1:0] step_up;
    logic [NumLevels-1:0] step_down;
    logic [BarWidth-1:0] placed;
    logic [BarWidth-1:0] lvl;
    logic [BarWidth-1:0] lvl_m1;

    assign out_en    = !out_valid_reg || !out_stall;
    assign meas_take = out_en;
    assign load      = out_en && meas_valid;

    always_comb begin
        for (int k = 0; k < NumLevels; k++)
        begin
            reach[k]     = meas.mean >= cfg.thr[k];
            step_up[k]   = {1'b0, meas.mean} >= ({1'b0, cfg.thr[k]} + (MvWidth+1)'(cfg.hyst));
            // mean < thr - hyst, kept unsigned by moving hyst to the other side
            step_down[k] = ({1'b0, meas.mean} + (MvWidth+1)'(cfg.hyst)) < {1'b0, cfg.thr[k]};
        end

        // First reading after reset or after an invalid one: highest threshold reached wins.
        if (reach[3])
            placed = 3'd4;
        else if (reach[2])
            placed = 3'd3;
        else if (reach[1])
            placed = 3'd2;
        else if (reach[0])
            placed = 3'd1;
        else
            placed = 3'd0;

        // Climb first, then descend; each walk stops at the first failed test.
        lvl = bar_level_reg;
        for (int i = 0; i < NumLevels; i++)
        begin
            if (lvl < BAR_MAX && step_up[lvl[1:0]])
                lvl = lvl + 3'd1;
        end
        for (int i = 0; i < NumLevels; i++)
        begin
            lvl_m1 = lvl - 3'd1;
            if (lvl != 3'd0 && step_down[lvl_m1[1:0]])
                lvl = lvl_m1;
        end
        lvl_m1 = lvl - 3'd1;

        if (!meas.ok)
            bar_level_next = '0;
        else if (!level_known_reg)
            bar_level_next = placed;
        else
            bar_level_next = lvl;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            level_known_reg <= 1'b0;
            bar_level_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_en)
            begin
                out_valid_reg <= meas_valid;
            end
            if (load)
            begin
                level_known_reg <= meas.ok;
                bar_level_reg   <= bar_level_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load)
        begin
            bar_count_reg     <= bar_level_next;
            reading_valid_reg <= meas.ok;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bar_count     = bar_count_reg;
    assign reading_valid = reading_valid_reg;

endmodule

[hdl/battery_bar_gauge_hysteresis.sv]
// Path: an accepted word is held in the input register, then in the measurement register,
// then in the result register on the outputs, from which it is taken when not stalled.
// Throughput: one word per cycle while the output is not stalled; the bar level register
// is read and written in the same cycle, so consecutive readings follow each other with no gap.
// Each stage holds its word while the next one is full and cannot move on, so input keeps flowing into bubbles.
// Reset clears the configuration to its defaults, forgets the bar level and empties all stages.
// ----------------------------------------------------------------------------
// battery_bar_gauge_hysteresis
// Turns three cell voltages into a battery bar count with hysteresis.
// ----------------------------------------------------------------------------
module battery_bar_gauge_hysteresis (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bbg_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [bbg_pkg::MvWidth-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bbg_pkg::CellWidth-1:0]   cell_a_mv,
    input  logic [bbg_pkg::CellWidth-1:0]   cell_b_mv,
    input  logic [bbg_pkg::CellWidth-1:0]   cell_c_mv,
    input  logic                            monitor_present,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bbg_pkg::BarWidth-1:0]    bar_count,
    output logic                            reading_valid
);
    import bbg_pkg::*;

    cfg_t  cfg;
    meas_t meas;
    logic  meas_valid;
    logic  meas_take;

    bbg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bbg_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cell_a_mv       (cell_a_mv),
        .cell_b_mv       (cell_b_mv),
        .cell_c_mv       (cell_c_mv),
        .monitor_present (monitor_present),
        .meas_valid      (meas_valid),
        .meas_take       (meas_take),
        .meas            (meas)
    );

    bbg_level u_level (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .meas_valid    (meas_valid),
        .meas_take     (meas_take),
        .meas          (meas),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .bar_count     (bar_count),
        .reading_valid (reading_valid)
    );

endmodule

[hdl/bbg_checker.sv]
// ----------------------------------------------------------------------------
// bbg_checker
// Port-level checks for the battery bar gauge, bound to the top level.
// ----------------------------------------------------------------------------
module bbg_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bbg_pkg::BarWidth-1:0] bar_count,
    input logic                         reading_valid
);
    import bbg_pkg::*;

    // An invalid reading always shows an empty gauge.
    a_invalid_shows_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reading_valid |-> bar_count == '0)
        else $error("invalid reading shows bars");

    // The gauge never shows more than four bars.
    a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bar_count <= BAR_MAX)
        else $error("bar count out of range");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bar_count) && $stable(reading_valid))
        else $error("stalled result changed");

    // No result appears in the cycle after reset was seen.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result present right after reset");

endmodule

bind battery_bar_gauge_hysteresis bbg_checker u_bbg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bar_count     (bar_count),
    .reading_valid (reading_valid)
);
